// ===== design/iopm_pkg.sv =====
// shared constants and controller/datapath interface types for the io performance monitor
`default_nettype none
package iopm_pkg;

	localparam int LATENCY_BITS_DEF = 32;
	localparam int WINDOW_LEN_W = 32;
	localparam logic [WINDOW_LEN_W-1:0] WINDOW_RESET = 32'd1000000;

	localparam logic [1:0] KIND_READ = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;

	localparam logic REG_WINDOW_LEN = 1'b0;

	typedef struct packed {
		logic capture;
		logic update;
		logic load_fast;
		logic load_regs;
		logic sum;
		logic diff;
		logic scale1;
		logic scale2;
		logic div_step;
		logic sel_bytes;
	} dp_cmd_t;

	typedef struct packed {
		logic close;
		logic div_last;
	} dp_status_t;

endpackage
`default_nettype wire

// ===== design/iopm_ctrl.sv =====
// controller state machine: item sequencing, rate computation steps and output handshake
`default_nettype none
module iopm_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output iopm_pkg::dp_cmd_t         cmd,
	input  wire iopm_pkg::dp_status_t st
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_UPD  = 3'd1;
	localparam logic [2:0] ST_SUM  = 3'd2;
	localparam logic [2:0] ST_DIFF = 3'd3;
	localparam logic [2:0] ST_SCL1 = 3'd4;
	localparam logic [2:0] ST_SCL2 = 3'd5;
	localparam logic [2:0] ST_DIV  = 3'd6;
	localparam logic [2:0] ST_EMIT = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       sel_q;
	logic       sel_d;
	logic       valid_q;
	logic       out_free;
	logic       out_load;

	assign out_free = !valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = valid_q;

	always_comb begin
		state_d = state_q;
		sel_d = sel_q;
		cmd = '0;
		cmd.sel_bytes = sel_q;
		cmd.capture = s_tvalid && s_tready;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				if (st.close) begin
					sel_d = 1'b0;
					state_d = ST_SUM;
				end else if (out_free) begin
					cmd.load_fast = 1'b1;
					out_load = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d = ST_SCL1;
			end
			ST_SCL1: begin
				cmd.scale1 = 1'b1;
				state_d = ST_SCL2;
			end
			ST_SCL2: begin
				cmd.scale2 = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last) begin
					if (sel_q) begin
						state_d = ST_EMIT;
					end else begin
						sel_d = 1'b1;
						state_d = ST_SUM;
					end
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.load_regs = 1'b1;
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q <= sel_d;
			if (out_load) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/iopm_dp.sv =====
// datapath: counters, latency averages, window tracking, rate divider and output register
`default_nettype none
module iopm_dp #(
	parameter int LATENCY_BITS = iopm_pkg::LATENCY_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire iopm_pkg::dp_cmd_t                      cmd,
	output iopm_pkg::dp_status_t                        st,
	input  wire logic [127:0]                           s_tdata,
	input  wire logic [2:0]                             s_tuser,
	input  wire logic [iopm_pkg::WINDOW_LEN_W-1:0]      window_len,
	output logic [511:0]                                m_tdata,
	output logic [0:0]                                  m_tuser
);

	localparam int LW = LATENCY_BITS;

	// captured item
	logic [1:0]    kind_q;
	logic          ok_q;
	logic [31:0]   nbytes_q;
	logic [LW-1:0] lat_q;
	logic [63:0]   now_q;

	// statistics
	logic [63:0]   reads_q;
	logic [63:0]   writes_q;
	logic [63:0]   bytes_in_q;
	logic [63:0]   bytes_out_q;
	logic [LW-1:0] rd_ema_q;
	logic [LW-1:0] wr_ema_q;
	logic [63:0]   failures_q;
	logic [63:0]   rate_ops_q;
	logic [63:0]   rate_bytes_q;
	logic [63:0]   ops_start_q;
	logic [63:0]   bytes_start_q;
	logic [63:0]   begin_q;
	logic          close_q;

	// rate computation
	logic [63:0]   elapsed_q;
	logic [63:0]   val_q;
	logic [63:0]   dvd_q;
	logic [63:0]   rem_q;
	logic [5:0]    cnt_q;

	logic [63:0]   reads_d;
	logic [63:0]   writes_d;
	logic [63:0]   bytes_in_d;
	logic [63:0]   bytes_out_d;
	logic [LW-1:0] rd_ema_d;
	logic [LW-1:0] wr_ema_d;
	logic [63:0]   failures_d;
	logic [LW+3:0] rd_sum;
	logic [LW+3:0] wr_sum;
	logic [63:0]   elapsed;
	logic [63:0]   win;
	logic [64:0]   trial;
	logic          qbit;
	logic [63:0]   quo_next;

	// floor((7*avg + lat)/8), exact at LW+4 bits
	assign rd_sum = ({4'b0, rd_ema_q} << 3) - {4'b0, rd_ema_q} + {4'b0, lat_q};
	assign wr_sum = ({4'b0, wr_ema_q} << 3) - {4'b0, wr_ema_q} + {4'b0, lat_q};

	always_comb begin
		reads_d = reads_q;
		writes_d = writes_q;
		bytes_in_d = bytes_in_q;
		bytes_out_d = bytes_out_q;
		rd_ema_d = rd_ema_q;
		wr_ema_d = wr_ema_q;
		failures_d = failures_q;
		if (ok_q) begin
			if (kind_q == iopm_pkg::KIND_READ) begin
				reads_d = reads_q + 64'd1;
				bytes_in_d = bytes_in_q + {32'b0, nbytes_q};
				rd_ema_d = (reads_q == 64'd0) ? lat_q : rd_sum[LW+2:3];
			end else if (kind_q == iopm_pkg::KIND_WRITE) begin
				writes_d = writes_q + 64'd1;
				bytes_out_d = bytes_out_q + {32'b0, nbytes_q};
				wr_ema_d = (writes_q == 64'd0) ? lat_q : wr_sum[LW+2:3];
			end
		end else begin
			failures_d = failures_q + 64'd1;
		end
	end

	assign win = (window_len == '0) ? 64'd1 : {32'b0, window_len};
	assign elapsed = now_q - begin_q;
	assign st.close = (elapsed >= win);

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, dvd_q[63]} - {1'b0, elapsed_q};
	assign qbit = !trial[64];
	assign quo_next = {dvd_q[62:0], qbit};
	assign st.div_last = (cnt_q == 6'd63);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			nbytes_q <= s_tdata[31:0];
			lat_q <= LW'(s_tdata[63:32]);
			now_q <= s_tdata[127:64];
			kind_q <= s_tuser[1:0];
			ok_q <= s_tuser[2];
		end
		if (cmd.update) begin
			elapsed_q <= elapsed;
		end
		if (cmd.sum) begin
			val_q <= cmd.sel_bytes ? (bytes_in_q + bytes_out_q) : (reads_q + writes_q);
		end else if (cmd.diff) begin
			val_q <= val_q - (cmd.sel_bytes ? bytes_start_q : ops_start_q);
		end
		// x1000000 as 2^20 - 2^16 + 2^14 + 2^9 + 2^6
		if (cmd.scale1) begin
			dvd_q <= (val_q << 20) - (val_q << 16) + (val_q << 14);
		end else if (cmd.scale2) begin
			dvd_q <= dvd_q + (val_q << 9) + (val_q << 6);
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= quo_next;
			rem_q <= qbit ? trial[63:0] : {rem_q[62:0], dvd_q[63]};
			cnt_q <= cnt_q + 6'd1;
		end
		if (cmd.load_fast) begin
			m_tdata <= {rate_bytes_q, rate_ops_q, failures_d, 32'(wr_ema_d), 32'(rd_ema_d),
				bytes_out_d, bytes_in_d, writes_d, reads_d};
			m_tuser <= 1'b0;
		end else if (cmd.load_regs) begin
			m_tdata <= {rate_bytes_q, rate_ops_q, failures_q, 32'(wr_ema_q), 32'(rd_ema_q),
				bytes_out_q, bytes_in_q, writes_q, reads_q};
			m_tuser <= close_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reads_q <= '0;
			writes_q <= '0;
			bytes_in_q <= '0;
			bytes_out_q <= '0;
			rd_ema_q <= '0;
			wr_ema_q <= '0;
			failures_q <= '0;
			rate_ops_q <= '0;
			rate_bytes_q <= '0;
			ops_start_q <= '0;
			bytes_start_q <= '0;
			begin_q <= '0;
			close_q <= 1'b0;
		end else begin
			if (cmd.update) begin
				reads_q <= reads_d;
				writes_q <= writes_d;
				bytes_in_q <= bytes_in_d;
				bytes_out_q <= bytes_out_d;
				rd_ema_q <= rd_ema_d;
				wr_ema_q <= wr_ema_d;
				failures_q <= failures_d;
				close_q <= st.close;
				if (st.close) begin
					begin_q <= now_q;
				end
			end
			if (cmd.diff) begin
				if (cmd.sel_bytes) begin
					bytes_start_q <= val_q;
				end else begin
					ops_start_q <= val_q;
				end
			end
			if (cmd.div_step && st.div_last) begin
				if (cmd.sel_bytes) begin
					rate_bytes_q <= quo_next;
				end else begin
					rate_ops_q <= quo_next;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/io_performance_monitor.sv =====
// top level: io completion statistics with moving-average latency and windowed rates
// an item passes the accept and update states; the result register is loaded in the update
// state if no window closes and the output register is free, else in the emit state once it is
// free; an item that closes a window first runs two radix-2 divisions in one shared divider,
// each after a sum, difference and two-step scale setup
// a new item is accepted while the previous result still waits in the output register
// arst_n clears all counters, averages, rates and window state; window length resets to 1000000
`default_nettype none
module io_performance_monitor #(
	parameter int LATENCY_BITS = iopm_pkg::LATENCY_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// tdata: byte_count[31:0], op_latency[63:32], now_us[127:64]
	input  wire logic [127:0] s_tdata,
	// tuser: io_kind[1:0], ok[2]
	input  wire logic [2:0]   s_tuser,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// tdata: read_op_total[63:0], write_op_total[127:64], read_byte_total[191:128],
	// write_byte_total[255:192], read_latency_avg[287:256], write_latency_avg[319:288],
	// error_total[383:320], ops_per_second[447:384], bytes_per_second[511:448]
	output logic [511:0]      m_tdata,
	// tuser: window_closed[0]
	output logic [0:0]        m_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	iopm_pkg::dp_cmd_t                  cmd;
	iopm_pkg::dp_status_t               st;
	logic [iopm_pkg::WINDOW_LEN_W-1:0]  window_len_q;
	logic                               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == iopm_pkg::REG_WINDOW_LEN);
	assign prdata = (paddr[2] == iopm_pkg::REG_WINDOW_LEN) ? window_len_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= iopm_pkg::WINDOW_RESET;
		end else if (cfg_wr) begin
			window_len_q <= pwdata;
		end
	end

	iopm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.st       (st)
	);

	iopm_dp #(
		.LATENCY_BITS (LATENCY_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.window_len (window_len_q),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

	// one item in flight: no transfer in the cycle after an accepted one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while previous item still updating");

	// a result appears only after an item was being worked on
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result raised without an item in progress");

	// window length write lands in the register
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> window_len_q == $past(pwdata))
		else $error("window length write lost");

endmodule
`default_nettype wire

// ===== bench/tb_io_performance_monitor.sv =====
// self-checking bench for the io performance monitor: counters, latency averages, window rates
module tb_io_performance_monitor;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] KIND_OTHER = 2'd2;
	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam logic [2:0] WINDOW_LEN_ADDR = {iopm_pkg::REG_WINDOW_LEN, 2'b00};
	localparam int STUCK_LIMIT = 4000;
	localparam int SINK_HOLD_CYCLES = 400;
	localparam int END_WAIT_CYCLES = 200;

	typedef struct packed {
		logic [1:0]  kind;
		logic        ok;
		logic [31:0] nbytes;
		logic [31:0] lat;
		logic [63:0] now;
	} completion_t;

	typedef struct packed {
		logic [63:0] rd_ops;
		logic [63:0] wr_ops;
		logic [63:0] rd_bytes;
		logic [63:0] wr_bytes;
		logic [31:0] rd_lat;
		logic [31:0] wr_lat;
		logic [63:0] errs;
		logic [63:0] ops_ps;
		logic [63:0] bytes_ps;
		logic        closed;
	} stats_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic [127:0] s_tdata = '0;
	logic [2:0]   s_tuser = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [511:0] m_tdata;
	logic [0:0]   m_tuser;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [2:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	// predictor state
	logic [63:0] reads_seen = '0;
	logic [63:0] writes_seen = '0;
	logic [63:0] bytes_read = '0;
	logic [63:0] bytes_written = '0;
	logic [31:0] rd_lat_avg = '0;
	logic [31:0] wr_lat_avg = '0;
	logic [63:0] fail_count = '0;
	logic [63:0] ops_rate = '0;
	logic [63:0] byte_rate = '0;
	logic [63:0] ops_mark = '0;
	logic [63:0] bytes_mark = '0;
	logic [63:0] mark_us = '0;
	logic [31:0] win_len = iopm_pkg::WINDOW_RESET;

	completion_t completion_q[$];
	stats_t      due_stats[$];
	completion_t taken_item;
	stats_t      seen_stats;
	stats_t      head_stats;
	logic        s_taken = 1'b0;
	logic        calm = 1'b0;
	logic        hold_req = 1'b0;
	int          src_gap = 0;
	int          sink_gap = 0;
	int          sink_hold = 0;
	int          stuck = 0;
	int          mismatches = 0;
	logic [63:0] clock_us = '0;
	logic [31:0] win_plan[6];

	io_performance_monitor u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	function automatic logic [31:0] blend_latency(input logic [31:0] avg, input logic [31:0] lat);
		logic [34:0] acc;
		acc = {3'b000, avg} * 35'd7 + {3'b000, lat};
		return acc[34:3];
	endfunction

	function automatic stats_t tally_completion(input completion_t c);
		stats_t r;
		logic [63:0] span;
		logic [63:0] elapsed;
		logic [63:0] ops;
		logic [63:0] bytes;
		r.closed = 1'b0;
		if (c.ok) begin
			if (c.kind == iopm_pkg::KIND_READ) begin
				reads_seen = reads_seen + 64'd1;
				bytes_read = bytes_read + {32'd0, c.nbytes};
				rd_lat_avg = (reads_seen == 64'd1) ? c.lat : blend_latency(rd_lat_avg, c.lat);
			end else if (c.kind == iopm_pkg::KIND_WRITE) begin
				writes_seen = writes_seen + 64'd1;
				bytes_written = bytes_written + {32'd0, c.nbytes};
				wr_lat_avg = (writes_seen == 64'd1) ? c.lat : blend_latency(wr_lat_avg, c.lat);
			end
		end else begin
			fail_count = fail_count + 64'd1;
		end
		// a zero window length behaves as one microsecond
		span = (win_len == 32'd0) ? 64'd1 : {32'd0, win_len};
		elapsed = c.now - mark_us;
		if (elapsed >= span) begin
			ops = reads_seen + writes_seen;
			bytes = bytes_read + bytes_written;
			ops_rate = ((ops - ops_mark) * 64'd1000000) / elapsed;
			byte_rate = ((bytes - bytes_mark) * 64'd1000000) / elapsed;
			ops_mark = ops;
			bytes_mark = bytes;
			mark_us = c.now;
			r.closed = 1'b1;
		end
		r.rd_ops = reads_seen;
		r.wr_ops = writes_seen;
		r.rd_bytes = bytes_read;
		r.wr_bytes = bytes_written;
		r.rd_lat = rd_lat_avg;
		r.wr_lat = wr_lat_avg;
		r.errs = fail_count;
		r.ops_ps = ops_rate;
		r.bytes_ps = byte_rate;
		return r;
	endfunction

	function automatic stats_t split_stats(input logic [511:0] d, input logic u);
		stats_t r;
		r.rd_ops = d[63:0];
		r.wr_ops = d[127:64];
		r.rd_bytes = d[191:128];
		r.wr_bytes = d[255:192];
		r.rd_lat = d[287:256];
		r.wr_lat = d[319:288];
		r.errs = d[383:320];
		r.ops_ps = d[447:384];
		r.bytes_ps = d[511:448];
		r.closed = u;
		return r;
	endfunction

	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 3))
			0: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
			1: return $urandom_range(0, 4096);
			default: return $urandom;
		endcase
	endfunction

	task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %s: expected %h, got %h", what, want, got);
		end
	endtask

	task automatic push_item(input logic [1:0] kind, input logic ok, input logic [31:0] nbytes,
			input logic [31:0] lat, input logic [63:0] now);
		completion_t c;
		c.kind = kind;
		c.ok = ok;
		c.nbytes = nbytes;
		c.lat = lat;
		c.now = now;
		completion_q.push_back(c);
	endtask

	task automatic queue_random(input int count);
		int r;
		logic [1:0] kind;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				kind = iopm_pkg::KIND_READ;
			else if (r < 90)
				kind = iopm_pkg::KIND_WRITE;
			else
				kind = 2'($urandom_range(2, 3));
			case ($urandom_range(0, 19))
				0: clock_us = {$urandom, $urandom};
				1, 2, 3, 4: clock_us = clock_us + {32'd0, win_len} + $urandom_range(0, 2);
				default: clock_us = clock_us + $urandom_range(0, 3);
			endcase
			push_item(kind, $urandom_range(0, 9) != 0, pick_word(), pick_word(), clock_us);
		end
	endtask

	task automatic drain();
		while (completion_q.size() != 0 || due_stats.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_window(input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= WINDOW_LEN_ADDR;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		win_len = value;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		psel <= 1'b1;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field("window_length_us readback", {32'd0, value}, {32'd0, prdata});
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		forever #10 clk = ~clk;
	end

	// input side
	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && !s_taken)) begin
			if (s_taken) begin
				s_taken = 1'b0;
				src_gap = draw_gap();
			end
			if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (completion_q.size() != 0) begin
				s_tdata <= {completion_q[0].now, completion_q[0].lat, completion_q[0].nbytes};
				s_tuser <= {completion_q[0].ok, completion_q[0].kind};
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// output side
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			sink_hold = SINK_HOLD_CYCLES;
		end
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (sink_hold > 0) begin
			sink_hold--;
			m_tready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			sink_gap = draw_gap();
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				seen_stats = split_stats(m_tdata, m_tuser[0]);
				if (due_stats.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: result transfer with nothing expected, data %h",
							m_tdata);
				end else begin
					head_stats = due_stats.pop_front();
					check_field("read_op_total", head_stats.rd_ops, seen_stats.rd_ops);
					check_field("write_op_total", head_stats.wr_ops, seen_stats.wr_ops);
					check_field("read_byte_total", head_stats.rd_bytes, seen_stats.rd_bytes);
					check_field("write_byte_total", head_stats.wr_bytes, seen_stats.wr_bytes);
					check_field("read_latency_avg", {32'd0, head_stats.rd_lat},
						{32'd0, seen_stats.rd_lat});
					check_field("write_latency_avg", {32'd0, head_stats.wr_lat},
						{32'd0, seen_stats.wr_lat});
					check_field("error_total", head_stats.errs, seen_stats.errs);
					check_field("ops_per_second", head_stats.ops_ps, seen_stats.ops_ps);
					check_field("bytes_per_second", head_stats.bytes_ps, seen_stats.bytes_ps);
					check_field("window_closed", {63'd0, head_stats.closed},
						{63'd0, seen_stats.closed});
				end
			end
			if (s_tvalid && s_tready) begin
				taken_item.kind = s_tuser[1:0];
				taken_item.ok = s_tuser[2];
				taken_item.nbytes = s_tdata[31:0];
				taken_item.lat = s_tdata[63:32];
				taken_item.now = s_tdata[127:64];
				due_stats.push_back(tally_completion(taken_item));
				void'(completion_q.pop_front());
				s_taken = 1'b1;
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stuck = 0;
		end else begin
			stuck++;
			if (stuck >= STUCK_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part at the reset window length
		push_item(iopm_pkg::KIND_READ, 1'b1, 32'd0, 32'd0, 64'd0);
		push_item(iopm_pkg::KIND_READ, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd10);
		push_item(iopm_pkg::KIND_READ, 1'b1, 32'd1, 32'hFFFF_FFFF, 64'd20);
		push_item(iopm_pkg::KIND_WRITE, 1'b1, 32'd4096, 32'd100, 64'd30);
		push_item(iopm_pkg::KIND_WRITE, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd40);
		push_item(iopm_pkg::KIND_WRITE, 1'b1, 32'd0, 32'd0, 64'd50);
		push_item(KIND_OTHER, 1'b1, 32'd555, 32'd77, 64'd60);
		push_item(KIND_SPARE, 1'b1, 32'd555, 32'd77, 64'd70);
		push_item(iopm_pkg::KIND_READ, 1'b0, 32'd8, 32'd9, 64'd80);
		push_item(iopm_pkg::KIND_WRITE, 1'b0, 32'd8, 32'd9, 64'd90);
		push_item(KIND_OTHER, 1'b0, 32'd1, 32'd1, 64'd100);
		push_item(KIND_SPARE, 1'b0, 32'd1, 32'd1, 64'd110);
		push_item(iopm_pkg::KIND_READ, 1'b1, 32'd512, 32'd7, 64'd999999);
		push_item(iopm_pkg::KIND_WRITE, 1'b1, 32'd512, 32'd8, 64'd1000000);
		push_item(iopm_pkg::KIND_READ, 1'b1, 32'd1, 32'd1, 64'd1999999);
		push_item(iopm_pkg::KIND_READ, 1'b1, 32'd1, 32'd1, 64'd2000000);
		// time running backwards
		push_item(iopm_pkg::KIND_WRITE, 1'b1, 32'hFFFF_FFFF, 32'd3, 64'd5);
		push_item(iopm_pkg::KIND_READ, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFFF);
		push_item(iopm_pkg::KIND_READ, 1'b1, 32'hAAAA_AAAA, 32'h5555_5555,
			64'h5555_5555_5555_5555);
		push_item(iopm_pkg::KIND_WRITE, 1'b1, 32'h5555_5555, 32'hAAAA_AAAA,
			64'hAAAA_AAAA_AAAA_AAAA);
		clock_us = 64'hAAAA_AAAA_AAAA_AAAA;

		win_plan[0] = 32'd0;
		win_plan[1] = 32'd1;
		win_plan[2] = 32'hFFFF_FFFF;
		win_plan[3] = $urandom_range(2, 64);
		win_plan[4] = $urandom;
		win_plan[5] = iopm_pkg::WINDOW_RESET;
		for (int i = 0; i < 6; i++) begin
			drain();
			write_window(win_plan[i]);
			calm = (i % 2) != 0;
			// long receiver stall while the sender keeps offering
			if (i == 1)
				hold_req = 1'b1;
			queue_random(250);
		end
		drain();
		repeat (END_WAIT_CYCLES) @(posedge clk);
		if (mismatches == 0 && due_stats.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
